>>> rtl/wdd_pkg.sv
// ----------------------------------------------------------------------------
// wdd_pkg
// Shared types and constants for the weight drop detector.
// ----------------------------------------------------------------------------
package wdd_pkg;

   localparam int LayerWidth   = 16;
   localparam int WeightWidth  = 24;
   localparam int ThreshWidth  = 23;
   localparam int CountWidth   = 8;
   localparam int DropWidth    = WeightWidth + 1;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 23;

   // register indexes on the csr port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_IGNORE_LAYERS   = 3'd0,
      CSR_WINDOW_LAYERS   = 3'd1,
      CSR_DROP_THRESHOLD  = 3'd2,
      CSR_CONFIRM_COUNT   = 3'd3,
      CSR_COOLDOWN_LAYERS = 3'd4
   } csr_index_type;

   localparam logic [LayerWidth-1:0]  IgnoreLayersReset   = 16'd2;
   localparam logic [LayerWidth-1:0]  WindowLayersReset   = 16'd5;
   localparam logic [ThreshWidth-1:0] DropThresholdReset  = 23'd500;
   localparam logic [CountWidth-1:0]  ConfirmCountReset   = 8'd2;
   localparam logic [LayerWidth-1:0]  CooldownLayersReset = 16'd10;

   typedef struct packed {
      logic [LayerWidth-1:0]  ignore_layers;
      logic [LayerWidth-1:0]  window_layers;
      logic [ThreshWidth-1:0] drop_threshold;
      logic [CountWidth-1:0]  confirm_count;
      logic [LayerWidth-1:0]  cooldown_layers;
   } cfg_type;

   typedef struct packed {
      logic [LayerWidth-1:0]         layer_number;
      logic signed [WeightWidth-1:0] weight_estimate;
   } req_payload_type;

   typedef struct packed {
      logic                  drop_detected;
      logic                  hit_now;
      logic [CountWidth-1:0] hits_so_far;
      logic                  tripped_latched;
   } rsp_payload_type;

endpackage

>>> rtl/weight_drop_detector_unit.sv
// ----------------------------------------------------------------------------
// weight_drop_detector_unit
// Detects a sudden weight loss from one weight estimate per print layer.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall, and gives
// one result per item. An accepted item waits in the input register until
// it is judged against the history state and lands in the result register,
// so rsp_valid is registered behind both of them. Throughput is one item
// per cycle while rsp_ready keeps up, set by the single judge stage that
// updates the history as each result is loaded; while a result waits for
// rsp_ready the input register takes one more item and then req_ready drops.
// csr_ready is always high; write configuration only while the unit is empty.
module weight_drop_detector_unit
   import wdd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_payload_type         req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_payload_type         rsp_payload,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type         cfg;
   req_payload_type item_ff;
   logic            item_valid_ff, item_valid_in;
   rsp_payload_type result;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            fire;
   logic            req_take;

   wdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wdd_judge u_judge (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = item_valid_ff && advance;
   assign req_ready = !item_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = fire || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   // a detection always reports the sticky flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.drop_detected |-> rsp_payload.tripped_latched)
      else $error("detection without tripped flag");

   // a miss, skip or seed leaves the consecutive count at zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit_now |-> rsp_payload.hits_so_far == '0)
      else $error("hit count not cleared on miss");

   // a held item is never dropped while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff)
      else $error("stalled item lost");

   // once tripped, later results stay tripped
   assert property (@(posedge clock) disable iff (reset)
      fire && rsp_valid_ff && rsp_ff.tripped_latched |=> rsp_ff.tripped_latched)
      else $error("tripped flag cleared");

endmodule

>>> rtl/wdd_csr.sv
// ----------------------------------------------------------------------------
// wdd_csr
// Configuration registers, written through the csr valid/ready channel.
// ----------------------------------------------------------------------------
module wdd_csr
   import wdd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IGNORE_LAYERS:   cfg_in.ignore_layers   = csr_wdata[LayerWidth-1:0];
            CSR_WINDOW_LAYERS:   cfg_in.window_layers   = csr_wdata[LayerWidth-1:0];
            CSR_DROP_THRESHOLD:  cfg_in.drop_threshold  = csr_wdata[ThreshWidth-1:0];
            CSR_CONFIRM_COUNT:   cfg_in.confirm_count   = csr_wdata[CountWidth-1:0];
            CSR_COOLDOWN_LAYERS: cfg_in.cooldown_layers = csr_wdata[LayerWidth-1:0];
            default:             cfg_in = cfg_ff;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ignore_layers   <= IgnoreLayersReset;
         cfg_ff.window_layers   <= WindowLayersReset;
         cfg_ff.drop_threshold  <= DropThresholdReset;
         cfg_ff.confirm_count   <= ConfirmCountReset;
         cfg_ff.cooldown_layers <= CooldownLayersReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/wdd_judge.sv
// ----------------------------------------------------------------------------
// wdd_judge
// History state and the per-item judgement: instant and window drop, hit
// counting, confirmation and cooldown.
// ----------------------------------------------------------------------------
module wdd_judge
   import wdd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  cfg_type         cfg,
   input  req_payload_type item,
   output rsp_payload_type result
);

   logic                          have_history_ff, have_history_in;
   logic signed [WeightWidth-1:0] last_weight_ff, last_weight_in;
   logic [LayerWidth-1:0]         last_layer_ff, last_layer_in;
   logic signed [WeightWidth-1:0] ref_weight_ff, ref_weight_in;
   logic [LayerWidth-1:0]         ref_layer_ff, ref_layer_in;
   logic [CountWidth-1:0]         hit_count_ff, hit_count_in;
   logic [LayerWidth-1:0]         cooldown_ff, cooldown_in;
   logic                          tripped_ff, tripped_in;

   logic [LayerWidth-1:0]         layer_dist;
   logic                          win_move;
   logic signed [WeightWidth-1:0] ref_weight_eff;
   logic signed [DropWidth-1:0]   inst_loss;
   logic signed [DropWidth-1:0]   win_loss;
   logic signed [DropWidth-1:0]   thresh;
   logic                          hit;
   logic [CountWidth-1:0]         hit_count_next;
   logic                          skip;

   // judged-path arithmetic
   assign layer_dist     = item.layer_number - ref_layer_ff;
   assign win_move       = (layer_dist >= cfg.window_layers);
   assign ref_weight_eff = win_move ? last_weight_ff : ref_weight_ff;
   assign inst_loss      = DropWidth'(last_weight_ff) - DropWidth'(item.weight_estimate);
   assign win_loss       = DropWidth'(ref_weight_eff) - DropWidth'(item.weight_estimate);
   assign thresh         = $signed({{(DropWidth-ThreshWidth){1'b0}}, cfg.drop_threshold});
   assign hit            = (inst_loss >= thresh) || (win_loss >= thresh);
   assign hit_count_next = !hit ? '0 :
                           (&hit_count_ff) ? hit_count_ff : hit_count_ff + 1'b1;
   assign skip           = (item.layer_number <= cfg.ignore_layers) || (cooldown_ff != '0);

   always_comb begin
      have_history_in = have_history_ff;
      last_weight_in  = item.weight_estimate;
      last_layer_in   = item.layer_number;
      ref_weight_in   = item.weight_estimate;
      ref_layer_in    = item.layer_number;
      hit_count_in    = hit_count_ff;
      cooldown_in     = cooldown_ff;
      tripped_in      = tripped_ff;
      result          = '0;

      priority if (!have_history_ff) begin
         // seeding item
         have_history_in = 1'b1;
      end else if (skip) begin
         if (item.layer_number > cfg.ignore_layers) begin
            cooldown_in = cooldown_ff - 1'b1;
         end
         hit_count_in = '0;
      end else begin
         ref_weight_in  = ref_weight_eff;
         ref_layer_in   = win_move ? last_layer_ff : ref_layer_ff;
         hit_count_in   = hit_count_next;
         result.hit_now = hit;
         if (hit_count_next >= cfg.confirm_count) begin
            tripped_in           = 1'b1;
            cooldown_in          = cfg.cooldown_layers;
            result.drop_detected = 1'b1;
         end
      end

      result.hits_so_far     = hit_count_in;
      result.tripped_latched = tripped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_history_ff <= 1'b0;
         last_weight_ff  <= '0;
         last_layer_ff   <= '0;
         ref_weight_ff   <= '0;
         ref_layer_ff    <= '0;
         hit_count_ff    <= '0;
         cooldown_ff     <= '0;
         tripped_ff      <= 1'b0;
      end else if (fire) begin
         have_history_ff <= have_history_in;
         last_weight_ff  <= last_weight_in;
         last_layer_ff   <= last_layer_in;
         ref_weight_ff   <= ref_weight_in;
         ref_layer_ff    <= ref_layer_in;
         hit_count_ff    <= hit_count_in;
         cooldown_ff     <= cooldown_in;
         tripped_ff      <= tripped_in;
      end
   end

endmodule

>>> verif/wdd_checker.sv
// ----------------------------------------------------------------------------
// wdd_checker
// Scoreboard for the weight drop detector: mirrors the register writes,
// predicts one result per input transfer from its own copy of the history
// state and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module wdd_checker
   import wdd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_payload_type         req_payload,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_payload_type         rsp_payload,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output int                      fail_count,
   output int                      pending
);

   cfg_type                       cfg;
   logic                          have_hist;
   logic signed [WeightWidth-1:0] prev_weight;
   logic [LayerWidth-1:0]         prev_layer;
   logic signed [WeightWidth-1:0] base_weight;
   logic [LayerWidth-1:0]         base_layer;
   logic [CountWidth-1:0]         hit_run;
   logic [LayerWidth-1:0]         cool_left;
   logic                          tripped;

   rsp_payload_type expected_rsp_q[$];

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      fail_count++;
   endtask

   // Advances the history state by one layer and returns the result it yields.
   function automatic rsp_payload_type judge_layer(input req_payload_type item);
      rsp_payload_type               res;
      logic signed [WeightWidth-1:0] w;
      logic [LayerWidth-1:0]         span;
      logic signed [DropWidth-1:0]   thr;
      logic signed [DropWidth-1:0]   inst_drop;
      logic signed [DropWidth-1:0]   win_drop;
      res = '0;
      w = item.weight_estimate;
      if (!have_hist) begin
         have_hist   = 1'b1;
         prev_weight = w;
         prev_layer  = item.layer_number;
         base_weight = w;
         base_layer  = item.layer_number;
      end else if (item.layer_number <= cfg.ignore_layers || cool_left != '0) begin
         // low layers do not burn cooldown
         if (item.layer_number > cfg.ignore_layers)
            cool_left = cool_left - 1'b1;
         prev_weight = w;
         prev_layer  = item.layer_number;
         base_weight = w;
         base_layer  = item.layer_number;
         hit_run     = '0;
      end else begin
         thr = $signed({2'b00, cfg.drop_threshold});
         inst_drop = $signed({prev_weight[WeightWidth-1], prev_weight})
                   - $signed({w[WeightWidth-1], w});
         span = item.layer_number - base_layer;
         if (span >= cfg.window_layers) begin
            base_weight = prev_weight;
            base_layer  = prev_layer;
         end
         win_drop = $signed({base_weight[WeightWidth-1], base_weight})
                  - $signed({w[WeightWidth-1], w});
         res.hit_now = (inst_drop >= thr) || (win_drop >= thr);
         if (res.hit_now) begin
            if (hit_run != {CountWidth{1'b1}})
               hit_run = hit_run + 1'b1;
         end else begin
            hit_run = '0;
         end
         prev_weight = w;
         prev_layer  = item.layer_number;
         if (hit_run >= cfg.confirm_count) begin
            tripped           = 1'b1;
            cool_left         = cfg.cooldown_layers;
            res.drop_detected = 1'b1;
         end
      end
      res.hits_so_far     = hit_run;
      res.tripped_latched = tripped;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         cfg.ignore_layers   = IgnoreLayersReset;
         cfg.window_layers   = WindowLayersReset;
         cfg.drop_threshold  = DropThresholdReset;
         cfg.confirm_count   = ConfirmCountReset;
         cfg.cooldown_layers = CooldownLayersReset;
         have_hist   = 1'b0;
         prev_weight = '0;
         prev_layer  = '0;
         base_weight = '0;
         base_layer  = '0;
         hit_run     = '0;
         cool_left   = '0;
         tripped     = 1'b0;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         // pop before push so a result with nothing pending is never masked
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result transfer with no result pending");
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.drop_detected !== want.drop_detected)
                  report_mismatch($sformatf("drop_detected: expected %0d, got %0d",
                                            want.drop_detected, rsp_payload.drop_detected));
               if (rsp_payload.hit_now !== want.hit_now)
                  report_mismatch($sformatf("hit_now: expected %0d, got %0d",
                                            want.hit_now, rsp_payload.hit_now));
               if (rsp_payload.hits_so_far !== want.hits_so_far)
                  report_mismatch($sformatf("hits_so_far: expected %0d, got %0d",
                                            want.hits_so_far, rsp_payload.hits_so_far));
               if (rsp_payload.tripped_latched !== want.tripped_latched)
                  report_mismatch($sformatf("tripped_latched: expected %0d, got %0d",
                                            want.tripped_latched,
                                            rsp_payload.tripped_latched));
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(judge_layer(req_payload));
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_IGNORE_LAYERS:   cfg.ignore_layers   = csr_wdata[LayerWidth-1:0];
               CSR_WINDOW_LAYERS:   cfg.window_layers   = csr_wdata[LayerWidth-1:0];
               CSR_DROP_THRESHOLD:  cfg.drop_threshold  = csr_wdata[ThreshWidth-1:0];
               CSR_CONFIRM_COUNT:   cfg.confirm_count   = csr_wdata[CountWidth-1:0];
               CSR_COOLDOWN_LAYERS: cfg.cooldown_layers = csr_wdata[LayerWidth-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for weight_drop_detector_unit: directed layer sequences at the
// register extremes, then random weight traces under several settings, with
// bursty input, a stalling result side and one long result hold-off.
// ----------------------------------------------------------------------------
module tb;
   import wdd_pkg::*;

   localparam int CycleLimit    = 300000;
   localparam int HoldOffCycles = 120;
   localparam int DrainCycles   = 6;
   localparam int MaxWeight     = 8388607;
   localparam int MinWeight     = -8388608;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;

   int                    burst_left = 0;
   int                    max_gap = 0;
   bit                    hold_off_armed = 1'b0;
   logic [LayerWidth-1:0] seq_layer = '0;
   int                    seq_weight = 0;
   int                    seq_thr = 500;

   weight_drop_detector_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   wdd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("weight_drop_detector_unit regression: fail");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_payload_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_layer(input logic [LayerWidth-1:0] layer, input int weight);
      req_payload_type item;
      item.layer_number    = layer;
      item.weight_estimate = weight[WeightWidth-1:0];
      send_item(item);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      write_csr(CSR_IGNORE_LAYERS,   CsrDataWidth'(c.ignore_layers));
      write_csr(CSR_WINDOW_LAYERS,   CsrDataWidth'(c.window_layers));
      write_csr(CSR_DROP_THRESHOLD,  CsrDataWidth'(c.drop_threshold));
      write_csr(CSR_CONFIRM_COUNT,   CsrDataWidth'(c.confirm_count));
      write_csr(CSR_COOLDOWN_LAYERS, CsrDataWidth'(c.cooldown_layers));
      seq_thr = int'(c.drop_threshold);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Mostly a plausible weight trace, one layer per item, with drops around
   // the threshold, recoveries, skipped layers and some pure noise.
   task automatic run_traffic(input int count);
      int pick;
      int amount;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_layer(LayerWidth'($urandom), int'($urandom));
         end else begin
            if (pick < 14)
               seq_layer = seq_layer + LayerWidth'($urandom_range(0, 300));
            else
               seq_layer = seq_layer + 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 4)
               amount = seq_thr - 1;
            else if (pick < 8)
               amount = seq_thr;
            else if (pick < 16)
               amount = seq_thr + $urandom_range(1, 2000);
            else if (pick < 20)
               amount = -(seq_thr + 1);
            else
               amount = $urandom_range(0, seq_thr / 8 + 4) - (seq_thr / 16 + 2);
            seq_weight = seq_weight - amount;
            if (seq_weight > MaxWeight || seq_weight < MinWeight)
               seq_weight = $urandom_range(0, 200000) - 100000;
            send_layer(seq_layer, seq_weight);
         end
      end
   endtask

   // Result side: runs of a randomly chosen stall pattern out of four; one long
   // hold-off on request so the input side backs up.
   initial begin : result_sink
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_armed && rsp_valid) begin
            hold_off_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles - 1) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      cfg_type cfg;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: seeding, low layer, weight extremes, threshold edge,
      // window move, detection and a full cooldown
      max_gap = 4;
      send_layer(16'd3, 1000);
      send_layer(16'd1, MinWeight);
      send_layer(16'd4, MaxWeight);
      send_layer(16'd5, MinWeight);
      send_layer(16'd6, MinWeight);
      send_layer(16'd7, 2000);
      send_layer(16'd8, 1500);
      send_layer(16'd9, 1001);
      send_layer(16'd10, 500);
      send_layer(16'd11, 0);
      send_layer(16'd12, -5000);
      send_layer(16'd2, -5000);
      for (int i = 13; i < 22; i++)
         send_layer(i[LayerWidth-1:0], -5000);
      send_layer(16'd22, -6000);
      send_layer(16'd23, -4000);
      wait_idle();

      // all zero: no confirm needed, window moves every item, no cooldown
      cfg = '0;
      apply_config(cfg);
      send_layer(16'hFFFF, 0);
      send_layer(16'd0, 0);
      send_layer(16'd1, -100);
      wait_idle();

      // everything at its maximum: every layer is ignored
      cfg.ignore_layers   = '1;
      cfg.window_layers   = '1;
      cfg.drop_threshold  = '1;
      cfg.confirm_count   = '1;
      cfg.cooldown_layers = '1;
      apply_config(cfg);
      send_layer(16'hFFFF, -1);
      wait_idle();

      // largest threshold is still reachable by a full-scale drop
      cfg.ignore_layers   = '0;
      cfg.confirm_count   = 8'd1;
      cfg.cooldown_layers = '0;
      apply_config(cfg);
      send_layer(16'd5, MaxWeight);
      send_layer(16'd6, -1);
      send_layer(16'd7, MinWeight);
      wait_idle();

      // typical settings; the first stretch has no input gaps and carries
      // the long result hold-off
      cfg.ignore_layers   = LayerWidth'($urandom_range(0, 5));
      cfg.window_layers   = LayerWidth'($urandom_range(1, 8));
      cfg.drop_threshold  = ThreshWidth'($urandom_range(100, 1000));
      cfg.confirm_count   = CountWidth'($urandom_range(1, 4));
      cfg.cooldown_layers = LayerWidth'($urandom_range(0, 6));
      apply_config(cfg);
      seq_layer  = 16'd10;
      seq_weight = 50000;
      max_gap = 0;
      hold_off_armed = 1'b1;
      run_traffic(120);
      max_gap = 10;
      run_traffic(180);
      wait_idle();

      // zero threshold with a steady descent drives the hit count to its cap
      cfg = '0;
      apply_config(cfg);
      seq_weight = 0;
      for (int i = 0; i < 300; i++) begin
         seq_layer  = seq_layer + 1'b1;
         seq_weight = seq_weight - $urandom_range(0, 50);
         send_layer(seq_layer, seq_weight);
      end
      run_traffic(60);
      wait_idle();

      // settings drawn over the full register ranges; cooldown kept short
      for (int p = 0; p < 4; p++) begin
         cfg.ignore_layers   = LayerWidth'($urandom);
         cfg.window_layers   = LayerWidth'($urandom);
         cfg.drop_threshold  = ThreshWidth'($urandom);
         cfg.confirm_count   = CountWidth'($urandom);
         cfg.cooldown_layers = LayerWidth'($urandom_range(0, 20));
         apply_config(cfg);
         seq_layer = cfg.ignore_layers + LayerWidth'($urandom_range(1, 50));
         run_traffic(40);
         wait_idle();
      end

      // deep confirm count with a small threshold
      cfg.ignore_layers   = '0;
      cfg.window_layers   = LayerWidth'($urandom_range(0, 3));
      cfg.drop_threshold  = ThreshWidth'($urandom_range(0, 20));
      cfg.confirm_count   = CountWidth'($urandom_range(200, 255));
      cfg.cooldown_layers = 16'd3;
      apply_config(cfg);
      run_traffic(150);
      wait_idle();

      cfg.ignore_layers   = LayerWidth'($urandom_range(0, 5));
      cfg.window_layers   = LayerWidth'($urandom_range(1, 8));
      cfg.drop_threshold  = ThreshWidth'($urandom_range(100, 1000));
      cfg.confirm_count   = CountWidth'($urandom_range(1, 4));
      cfg.cooldown_layers = LayerWidth'($urandom_range(0, 6));
      apply_config(cfg);
      seq_layer = 16'd10;
      run_traffic(60);
      wait_idle();

      if (fail_count == 0)
         $display("weight_drop_detector_unit regression: pass");
      else
         $display("weight_drop_detector_unit regression: fail");
      $finish;
   end

endmodule
